@@ hdl/ita2_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ita2_pkg: shared types, codes and tables of the ITA2 codec
// holds the letters and figures tables, the item and result layouts and
// the saturating counter helper
// ----------------------------------------------------------------------------
package ita2_pkg;

	localparam int COUNT_BITS = 32;
	localparam int TOTAL_BITS = 32;

	typedef logic [COUNT_BITS-1:0] cnt_t;
	typedef logic [TOTAL_BITS-1:0] total_t;

	localparam logic [4:0] CODE_LTRS  = 5'd31;
	localparam logic [4:0] CODE_FIGS  = 5'd27;
	localparam logic [4:0] CODE_SPACE = 5'd4;
	localparam logic [4:0] CODE_NONE  = 5'd0;

	localparam logic ACT_ENCODE = 1'b0;
	localparam logic ACT_DECODE = 1'b1;

	localparam logic MODE_LTRS = 1'b0;
	localparam logic MODE_FIGS = 1'b1;

	typedef struct packed {
		logic       action;
		logic       start_of_message;
		logic [7:0] char_in;
		logic [7:0] code_in;
	} item_t;

	typedef struct packed {
		logic [4:0] code_out;
		logic       code_valid;
		logic [6:0] char_out;
		logic       char_valid;
		logic       error;
		logic       last;
		logic       mode_now;
		total_t     error_total;
		total_t     letters_shift_total;
		total_t     figures_shift_total;
	} result_t;

	// letters table
	function automatic logic [6:0] ltrs_char(input logic [4:0] code);
		logic [6:0] ch;
		case (code)
			5'd0:  ch = 7'h00;
			5'd1:  ch = 7'h45; // E
			5'd2:  ch = 7'h0A;
			5'd3:  ch = 7'h41; // A
			5'd4:  ch = 7'h20;
			5'd5:  ch = 7'h53; // S
			5'd6:  ch = 7'h49; // I
			5'd7:  ch = 7'h55; // U
			5'd8:  ch = 7'h0D;
			5'd9:  ch = 7'h44; // D
			5'd10: ch = 7'h52; // R
			5'd11: ch = 7'h4A; // J
			5'd12: ch = 7'h4E; // N
			5'd13: ch = 7'h46; // F
			5'd14: ch = 7'h43; // C
			5'd15: ch = 7'h4B; // K
			5'd16: ch = 7'h54; // T
			5'd17: ch = 7'h5A; // Z
			5'd18: ch = 7'h4C; // L
			5'd19: ch = 7'h57; // W
			5'd20: ch = 7'h48; // H
			5'd21: ch = 7'h59; // Y
			5'd22: ch = 7'h50; // P
			5'd23: ch = 7'h51; // Q
			5'd24: ch = 7'h4F; // O
			5'd25: ch = 7'h42; // B
			5'd26: ch = 7'h47; // G
			5'd28: ch = 7'h4D; // M
			5'd29: ch = 7'h58; // X
			5'd30: ch = 7'h56; // V
			default: ch = 7'h00;
		endcase
		return ch;
	endfunction

	// figures table, WRU and BEL are control bytes
	function automatic logic [6:0] figs_char(input logic [4:0] code);
		logic [6:0] ch;
		case (code)
			5'd0:  ch = 7'h00;
			5'd1:  ch = 7'h33; // 3
			5'd2:  ch = 7'h0A;
			5'd3:  ch = 7'h2D; // -
			5'd4:  ch = 7'h20;
			5'd5:  ch = 7'h27; // '
			5'd6:  ch = 7'h38; // 8
			5'd7:  ch = 7'h37; // 7
			5'd8:  ch = 7'h0D;
			5'd9:  ch = 7'h05; // wru
			5'd10: ch = 7'h34; // 4
			5'd11: ch = 7'h07; // bel
			5'd12: ch = 7'h2C; // ,
			5'd13: ch = 7'h21; // !
			5'd14: ch = 7'h3A; // :
			5'd15: ch = 7'h28; // (
			5'd16: ch = 7'h35; // 5
			5'd17: ch = 7'h22; // "
			5'd18: ch = 7'h29; // )
			5'd19: ch = 7'h32; // 2
			5'd20: ch = 7'h23; // #
			5'd21: ch = 7'h36; // 6
			5'd22: ch = 7'h30; // 0
			5'd23: ch = 7'h31; // 1
			5'd24: ch = 7'h39; // 9
			5'd25: ch = 7'h3F; // ?
			5'd26: ch = 7'h26; // &
			5'd28: ch = 7'h2E; // .
			5'd29: ch = 7'h2F; // /
			5'd30: ch = 7'h3D; // =
			default: ch = 7'h00;
		endcase
		return ch;
	endfunction

	// reverse lookup: {found, code}, printable entries only, lowest code wins
	function automatic logic [5:0] find_code(input logic [7:0] ch, input logic figs);
		logic [5:0] hit;
		logic [6:0] t;
		hit = 6'd0;
		for (int i = 31; i >= 0; i--) begin
			t = figs ? figs_char(5'(i)) : ltrs_char(5'(i));
			if (t >= 7'h20 && {1'b0, t} == ch) begin
				hit = {1'b1, 5'(i)};
			end
		end
		return hit;
	endfunction

	function automatic cnt_t bump(input cnt_t c);
		return (c == '1) ? c : cnt_t'(c + 1'b1);
	endfunction

endpackage
`default_nettype wire

@@ hdl/ita2_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ita2_step: single-pass encode/decode of one item
// works out the one or two results of an item and the next shift state
// ----------------------------------------------------------------------------
module ita2_step
	import ita2_pkg::*;
(
	input  item_t      item,
	input  logic       mode,
	input  cnt_t       err_cnt,
	input  cnt_t       ltrs_cnt,
	input  cnt_t       figs_cnt,
	output logic       two,
	output result_t    res0,
	output result_t    res1,
	output logic       mode_nxt,
	output cnt_t       err_cnt_nxt,
	output cnt_t       ltrs_cnt_nxt,
	output cnt_t       figs_cnt_nxt
);

	logic       m0;
	logic [7:0] uc;
	logic [5:0] lhit;
	logic [5:0] fhit;
	logic [4:0] dcode;
	logic [6:0] dch;

	always_comb begin
		m0 = item.start_of_message ? MODE_LTRS : mode;
		uc = (item.char_in >= 8'h61 && item.char_in <= 8'h7A) ?
			item.char_in - 8'h20 : item.char_in;
		lhit  = find_code(uc, MODE_LTRS);
		fhit  = find_code(uc, MODE_FIGS);
		dcode = item.code_in[4:0];
		dch   = m0 ? figs_char(dcode) : ltrs_char(dcode);

		two          = 1'b0;
		mode_nxt     = m0;
		err_cnt_nxt  = err_cnt;
		ltrs_cnt_nxt = ltrs_cnt;
		figs_cnt_nxt = figs_cnt;
		res0         = '0;
		res1         = '0;
		res0.last    = 1'b1;
		res1.last    = 1'b1;
		res1.code_valid = 1'b1;

		if (item.action == ACT_ENCODE) begin
			res0.code_valid = 1'b1;
			if (lhit[5]) begin
				if (m0 == MODE_FIGS) begin
					two          = 1'b1;
					mode_nxt     = MODE_LTRS;
					ltrs_cnt_nxt = bump(ltrs_cnt);
					res0.code_out = CODE_LTRS;
					res0.last     = 1'b0;
					res1.code_out = lhit[4:0];
				end else begin
					res0.code_out = lhit[4:0];
				end
			end else if (fhit[5]) begin
				if (m0 == MODE_LTRS) begin
					two          = 1'b1;
					mode_nxt     = MODE_FIGS;
					figs_cnt_nxt = bump(figs_cnt);
					res0.code_out = CODE_FIGS;
					res0.last     = 1'b0;
					res1.code_out = fhit[4:0];
				end else begin
					res0.code_out = fhit[4:0];
				end
			end else begin
				err_cnt_nxt   = bump(err_cnt);
				res0.code_out = CODE_SPACE;
				res0.error    = 1'b1;
			end
		end else begin
			if (dcode == CODE_LTRS) begin
				mode_nxt     = MODE_LTRS;
				ltrs_cnt_nxt = bump(ltrs_cnt);
			end else if (dcode == CODE_FIGS) begin
				mode_nxt     = MODE_FIGS;
				figs_cnt_nxt = bump(figs_cnt);
			end else begin
				res0.char_out   = dch;
				res0.char_valid = (dch != 7'h00);
			end
		end

		// status after the whole item goes on every result
		res0.mode_now            = mode_nxt;
		res0.error_total         = total_t'(err_cnt_nxt);
		res0.letters_shift_total = total_t'(ltrs_cnt_nxt);
		res0.figures_shift_total = total_t'(figs_cnt_nxt);
		res1.mode_now            = mode_nxt;
		res1.error_total         = total_t'(err_cnt_nxt);
		res1.letters_shift_total = total_t'(ltrs_cnt_nxt);
		res1.figures_shift_total = total_t'(figs_cnt_nxt);
	end

endmodule
`default_nettype wire

@@ hdl/ita2_outq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ita2_outq: two-entry result queue
// takes one or two results of an item at once and hands them out in order
// ----------------------------------------------------------------------------
module ita2_outq
	import ita2_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push_req,
	input  logic    two,
	input  result_t res0,
	input  result_t res1,
	output logic    push,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t head
);

	result_t   ent_q [2];
	logic [1:0] cnt_q;
	result_t   e0_nxt;
	result_t   e1_nxt;
	logic [1:0] cnt_nxt;
	logic [1:0] cnt_ap;
	logic       pop;
	logic       room;

	assign out_valid = (cnt_q != 2'd0);
	assign head      = ent_q[0];
	assign pop       = out_valid && !out_stall;

	always_comb begin
		e0_nxt = ent_q[0];
		e1_nxt = ent_q[1];
		cnt_ap = cnt_q;
		if (pop) begin
			e0_nxt = ent_q[1];
			cnt_ap = cnt_q - 2'd1;
		end
		room    = two ? (cnt_ap == 2'd0) : (cnt_ap != 2'd2);
		push    = push_req && room;
		cnt_nxt = cnt_ap;
		if (push) begin
			if (cnt_ap == 2'd0) begin
				e0_nxt  = res0;
				e1_nxt  = res1;
				cnt_nxt = two ? 2'd2 : 2'd1;
			end else begin
				e1_nxt  = res0;
				cnt_nxt = 2'd2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_nxt;
		end
	end

	always_ff @(posedge clk) begin
		ent_q[0] <= e0_nxt;
		ent_q[1] <= e1_nxt;
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result queue count out of range");

	a_pair_whole: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !head.last) |-> cnt_q == 2'd2)
		else $error("shift code queued without its character code");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(head.code_valid && head.char_valid))
		else $error("result carries both a code and a character");

	a_err_space: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && head.error) |-> (head.code_out == CODE_SPACE && head.last))
		else $error("error result is not a final space");

	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(push && two) |=> cnt_q == 2'd2)
		else $error("two-result item did not land whole");

endmodule
`default_nettype wire

@@ hdl/ita2_baudot_codec.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ita2_baudot_codec: streaming ITA2 codec with letters/figures shift
// encodes characters to 5-bit codes and decodes codes to characters
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid/in_stall with action, start_of_message,
//   char_in, code_in; an item is taken on a clock edge with in_valid high
//   and in_stall low
//   output channel: out_valid/out_stall with one result per handshake;
//   an encode item that needs a mode change gives two results (the shift
//   code with last low, then the character code with last high), every
//   other item gives exactly one
//   path: a taken item waits in the input register, then its results
//   move into the result queue, whose head drives the output
//   throughput: one item per cycle for single-result items while the
//   receiver does not stall; a shift-code item waits for an empty queue
//   reset: shift mode goes to letters, all counters to zero, nothing queued
//   receiver stall: results hold in a two-entry queue; once it has no room
//   for the item in the input register, in_stall rises and the input holds
// ----------------------------------------------------------------------------
module ita2_baudot_codec
	import ita2_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic        start_of_message,
	input  logic [7:0]  char_in,
	input  logic [7:0]  code_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  code_out,
	output logic        code_valid,
	output logic [6:0]  char_out,
	output logic        char_valid,
	output logic        error,
	output logic        last,
	output logic        mode_now,
	output logic [31:0] error_total,
	output logic [31:0] letters_shift_total,
	output logic [31:0] figures_shift_total
);

	// input register
	item_t   item_s1;
	logic    valid_s1;

	// codec state
	logic    mode_q;
	cnt_t    err_cnt_q;
	cnt_t    ltrs_cnt_q;
	cnt_t    figs_cnt_q;

	// step results
	logic    two;
	result_t res0;
	result_t res1;
	logic    mode_nxt;
	cnt_t    err_cnt_nxt;
	cnt_t    ltrs_cnt_nxt;
	cnt_t    figs_cnt_nxt;

	logic    push;
	result_t head;
	logic    in_take;

	// input register frees when its item moves into the queue
	assign in_stall = valid_s1 && !push;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= '{action, start_of_message, char_in, code_in};
		end
	end

	ita2_step u_step (
		.item         (item_s1),
		.mode         (mode_q),
		.err_cnt      (err_cnt_q),
		.ltrs_cnt     (ltrs_cnt_q),
		.figs_cnt     (figs_cnt_q),
		.two          (two),
		.res0         (res0),
		.res1         (res1),
		.mode_nxt     (mode_nxt),
		.err_cnt_nxt  (err_cnt_nxt),
		.ltrs_cnt_nxt (ltrs_cnt_nxt),
		.figs_cnt_nxt (figs_cnt_nxt)
	);

	// state moves only when the item's results are committed to the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_LTRS;
			err_cnt_q  <= '0;
			ltrs_cnt_q <= '0;
			figs_cnt_q <= '0;
		end else if (push) begin
			mode_q     <= mode_nxt;
			err_cnt_q  <= err_cnt_nxt;
			ltrs_cnt_q <= ltrs_cnt_nxt;
			figs_cnt_q <= figs_cnt_nxt;
		end
	end

	ita2_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_req  (valid_s1),
		.two       (two),
		.res0      (res0),
		.res1      (res1),
		.push      (push),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign code_out            = head.code_out;
	assign code_valid          = head.code_valid;
	assign char_out            = head.char_out;
	assign char_valid          = head.char_valid;
	assign error               = head.error;
	assign last                = head.last;
	assign mode_now            = head.mode_now;
	assign error_total         = head.error_total;
	assign letters_shift_total = head.letters_shift_total;
	assign figures_shift_total = head.figures_shift_total;

endmodule
`default_nettype wire

@@ bench/ita2_baudot_codec_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ita2_baudot_codec_test: self-checking bench of the ITA2 Baudot codec
// drives a directed table and then random encode/decode items through the
// valid/stall input, predicts every result in a local model of the shift
// mode and counters, and checks each output item field by field
// ----------------------------------------------------------------------------
module ita2_baudot_codec_test;
	import ita2_pkg::*;

	// cycles with no handshake on either side before the run is declared hung
	localparam int HANG_LIMIT = 2000;
	// items per random phase
	localparam int PHASE_ITEMS = 700;

	// one row of the directed table: the item and, where it is obvious,
	// the single result it must give
	typedef struct packed {
		item_t   it;
		logic    known;
		result_t want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        action = ACT_ENCODE;
	logic        start_of_message = 1'b0;
	logic [7:0]  char_in = 8'h00;
	logic [7:0]  code_in = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [4:0]  code_out;
	logic        code_valid;
	logic [6:0]  char_out;
	logic        char_valid;
	logic        error;
	logic        last;
	logic        mode_now;
	logic [31:0] error_total;
	logic [31:0] letters_shift_total;
	logic [31:0] figures_shift_total;

	// idling rates in percent, changed per phase by the main sequence
	int send_idle_pct = 11;
	int recv_stall_pct = 73;

	int fail_count = 0;
	int hang_cycles = 0;

	// local copy of the codec state
	logic cur_mode = MODE_LTRS;
	cnt_t err_cnt = '0;
	cnt_t ltrs_cnt = '0;
	cnt_t figs_cnt = '0;

	// results still owed by the block, oldest first
	result_t awaited_symbols[$];
	// results of the item just accepted
	result_t step_results[$];

	// ita2 tables, 0 where a code has no printable or control character
	logic [7:0] letters_set [32] = '{
		8'h00, "E",   8'h0A, "A",   " ",   "S",   "I",   "U",
		8'h0D, "D",   "R",   "J",   "N",   "F",   "C",   "K",
		"T",   "Z",   "L",   "W",   "H",   "Y",   "P",   "Q",
		"O",   "B",   "G",   8'h00, "M",   "X",   "V",   8'h00
	};
	logic [7:0] figures_set [32] = '{
		8'h00, "3",   8'h0A, "-",   " ",   "'",   "8",   "7",
		8'h0D, 8'h05, "4",   8'h07, ",",   "!",   ":",   "(",
		"5",   "\"",  ")",   "2",   "#",   "6",   "0",   "1",
		"9",   "?",   "&",   8'h00, ".",   "/",   "=",   8'h00
	};

	ita2_baudot_codec i_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.action              (action),
		.start_of_message    (start_of_message),
		.char_in             (char_in),
		.code_in             (code_in),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.code_out            (code_out),
		.code_valid          (code_valid),
		.char_out            (char_out),
		.char_valid          (char_valid),
		.error               (error),
		.last                (last),
		.mode_now            (mode_now),
		.error_total         (error_total),
		.letters_shift_total (letters_shift_total),
		.figures_shift_total (figures_shift_total)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic cnt_t sat_inc(input cnt_t c);
		if (c == {COUNT_BITS{1'b1}}) begin
			return c;
		end
		return c + 1'b1;
	endfunction

	// lowest code whose printable table entry equals ch, -1 if none
	function automatic int table_code(input logic [7:0] ch, input logic figs);
		logic [7:0] t;
		for (int i = 0; i < 32; i++) begin
			t = figs ? figures_set[i] : letters_set[i];
			if (t >= 8'h20 && t == ch) begin
				return i;
			end
		end
		return -1;
	endfunction

	// works out the results of one item and advances the local state
	task automatic baudot_step(input item_t it);
		logic [7:0] ch;
		logic [4:0] cd;
		logic [4:0] shift_val;
		logic [4:0] main_code;
		logic [7:0] dch;
		logic       need_shift;
		logic       bad_char;
		int         lc;
		int         fc;
		result_t    r;
		step_results.delete();
		need_shift = 1'b0;
		bad_char = 1'b0;
		shift_val = CODE_NONE;
		main_code = CODE_NONE;
		dch = 8'h00;
		lc = -1;
		fc = -1;
		// start of message drops back to letters without counting a shift
		if (it.start_of_message) begin
			cur_mode = MODE_LTRS;
		end
		if (it.action == ACT_ENCODE) begin
			ch = it.char_in;
			if (ch >= "a" && ch <= "z") begin
				ch = ch - 8'd32;
			end
			if (ch >= 8'h20 && ch < 8'h80) begin
				lc = table_code(ch, 1'b0);
				if (lc < 0) begin
					fc = table_code(ch, 1'b1);
				end
			end
			if (lc >= 0) begin
				// letters table wins, space included
				if (cur_mode == MODE_FIGS) begin
					need_shift = 1'b1;
					shift_val = CODE_LTRS;
					cur_mode = MODE_LTRS;
					ltrs_cnt = sat_inc(ltrs_cnt);
				end
				main_code = 5'(lc);
			end else if (fc >= 0) begin
				if (cur_mode == MODE_LTRS) begin
					need_shift = 1'b1;
					shift_val = CODE_FIGS;
					cur_mode = MODE_FIGS;
					figs_cnt = sat_inc(figs_cnt);
				end
				main_code = 5'(fc);
			end else begin
				// unmapped: space with error, mode kept
				bad_char = 1'b1;
				main_code = CODE_SPACE;
				err_cnt = sat_inc(err_cnt);
			end
		end else begin
			cd = it.code_in[4:0];
			if (cd == CODE_LTRS) begin
				cur_mode = MODE_LTRS;
				ltrs_cnt = sat_inc(ltrs_cnt);
			end else if (cd == CODE_FIGS) begin
				cur_mode = MODE_FIGS;
				figs_cnt = sat_inc(figs_cnt);
			end else begin
				dch = (cur_mode == MODE_FIGS) ? figures_set[cd] : letters_set[cd];
			end
		end
		r = '0;
		r.mode_now = cur_mode;
		r.error_total = total_t'(err_cnt);
		r.letters_shift_total = total_t'(ltrs_cnt);
		r.figures_shift_total = total_t'(figs_cnt);
		if (it.action == ACT_ENCODE) begin
			r.code_valid = 1'b1;
			if (need_shift) begin
				r.code_out = shift_val;
				r.last = 1'b0;
				step_results.push_back(r);
			end
			r.code_out = main_code;
			r.error = bad_char;
			r.last = 1'b1;
			step_results.push_back(r);
		end else begin
			r.char_out = dch[6:0];
			r.char_valid = (dch != 8'h00);
			r.last = 1'b1;
			step_results.push_back(r);
		end
	endtask

	task automatic flag_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $realtime, msg);
		fail_count++;
	endtask

	// compares one output item with the oldest awaited one
	task automatic check_symbol(input result_t got);
		result_t want;
		if (awaited_symbols.size() == 0) begin
			flag_mismatch($sformatf("result with nothing awaited, code %0d char %02h",
				got.code_out, got.char_out));
			return;
		end
		want = awaited_symbols.pop_front();
		if (got.code_out !== want.code_out)
			flag_mismatch($sformatf("code_out %0d, want %0d", got.code_out, want.code_out));
		if (got.code_valid !== want.code_valid)
			flag_mismatch($sformatf("code_valid %b, want %b", got.code_valid, want.code_valid));
		if (got.char_out !== want.char_out)
			flag_mismatch($sformatf("char_out %02h, want %02h", got.char_out, want.char_out));
		if (got.char_valid !== want.char_valid)
			flag_mismatch($sformatf("char_valid %b, want %b", got.char_valid, want.char_valid));
		if (got.error !== want.error)
			flag_mismatch($sformatf("error %b, want %b", got.error, want.error));
		if (got.last !== want.last)
			flag_mismatch($sformatf("last %b, want %b", got.last, want.last));
		if (got.mode_now !== want.mode_now)
			flag_mismatch($sformatf("mode_now %b, want %b", got.mode_now, want.mode_now));
		if (got.error_total !== want.error_total)
			flag_mismatch($sformatf("error_total %0d, want %0d",
				got.error_total, want.error_total));
		if (got.letters_shift_total !== want.letters_shift_total)
			flag_mismatch($sformatf("letters_shift_total %0d, want %0d",
				got.letters_shift_total, want.letters_shift_total));
		if (got.figures_shift_total !== want.figures_shift_total)
			flag_mismatch($sformatf("figures_shift_total %0d, want %0d",
				got.figures_shift_total, want.figures_shift_total));
	endtask

	// output side: check accepted items, then pick the stall for the next edge
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			check_symbol({code_out, code_valid, char_out, char_valid, error, last, mode_now,
				error_total, letters_shift_total, figures_shift_total});
		end
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// hang detector: counts edges with no handshake on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			hang_cycles = 0;
		end else begin
			hang_cycles++;
			if (hang_cycles >= HANG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// offers one item, waits for it to be taken and books its results
	task automatic send_item(input item_t it, input logic known, input result_t want);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= it.action;
		start_of_message <= it.start_of_message;
		char_in <= it.char_in;
		code_in <= it.code_in;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		baudot_step(it);
		if (known) begin
			awaited_symbols.push_back(want);
		end else begin
			foreach (step_results[k]) begin
				awaited_symbols.push_back(step_results[k]);
			end
		end
	endtask

	// sender holds off until the block has delivered everything owed
	task automatic drain_results();
		in_valid <= 1'b0;
		while (awaited_symbols.size() != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic stim_row_t plain_row(input logic a, input logic s,
		input logic [7:0] ch, input logic [7:0] cd);
		stim_row_t row;
		row = '0;
		row.it = {a, s, ch, cd};
		return row;
	endfunction

	// single encode/decode result in letters mode with no shifts counted yet
	function automatic stim_row_t known_row(input logic a, input logic [7:0] ch,
		input logic [7:0] cd, input logic [4:0] code, input logic err, input total_t etot);
		stim_row_t row;
		row = plain_row(a, 1'b0, ch, cd);
		row.known = 1'b1;
		row.want.code_out = code;
		row.want.code_valid = (a == ACT_ENCODE);
		row.want.error = err;
		row.want.last = 1'b1;
		row.want.mode_now = MODE_LTRS;
		row.want.error_total = etot;
		return row;
	endfunction

	initial begin
		stim_row_t dir_rows[$];
		item_t     it;
		int        pick;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed table: rows with a typed result come first, straight after reset
		dir_rows.push_back(known_row(ACT_ENCODE, "A", 8'h00, 5'd3, 1'b0, 32'd0));
		// carriage return and a high byte are unmapped and give an error space
		dir_rows.push_back(known_row(ACT_ENCODE, 8'h0D, 8'hFF, CODE_SPACE, 1'b1, 32'd1));
		dir_rows.push_back(known_row(ACT_ENCODE, 8'hFF, 8'h00, CODE_SPACE, 1'b1, 32'd2));
		// code 0 is silent
		dir_rows.push_back(known_row(ACT_DECODE, 8'hFF, 8'h00, CODE_NONE, 1'b0, 32'd2));
		// figure needs a figures shift first, then one that does not
		dir_rows.push_back(plain_row(ACT_ENCODE, 1'b0, "3", 8'h00));
		dir_rows.push_back(plain_row(ACT_ENCODE, 1'b0, "#", 8'h00));
		// lower case letter back to letters
		dir_rows.push_back(plain_row(ACT_ENCODE, 1'b0, "a", 8'h00));
		dir_rows.push_back(plain_row(ACT_ENCODE, 1'b0, " ", 8'h00));
		// decode side: figures shift, then wru and bel
		dir_rows.push_back(plain_row(ACT_DECODE, 1'b0, 8'h00, {3'd0, CODE_FIGS}));
		dir_rows.push_back(plain_row(ACT_DECODE, 1'b0, 8'h00, 8'h09));
		dir_rows.push_back(plain_row(ACT_DECODE, 1'b0, 8'h00, 8'h0B));
		// space while in figures still goes through the letters table
		dir_rows.push_back(plain_row(ACT_DECODE, 1'b0, 8'h00, {3'd0, CODE_FIGS}));
		dir_rows.push_back(plain_row(ACT_ENCODE, 1'b0, " ", 8'h00));
		// all-ones byte masks to the letters shift
		dir_rows.push_back(plain_row(ACT_DECODE, 1'b0, 8'h00, 8'hFF));
		// del, wru and bel bytes, nul and line feed cannot be encoded
		dir_rows.push_back(plain_row(ACT_ENCODE, 1'b0, 8'h7F, 8'h00));
		dir_rows.push_back(plain_row(ACT_ENCODE, 1'b0, 8'h05, 8'h00));
		dir_rows.push_back(plain_row(ACT_ENCODE, 1'b0, 8'h07, 8'h00));
		dir_rows.push_back(plain_row(ACT_ENCODE, 1'b0, 8'h00, 8'h00));
		dir_rows.push_back(plain_row(ACT_ENCODE, 1'b0, 8'h0A, 8'h00));
		// start flag in letters, then start flag out of figures
		dir_rows.push_back(plain_row(ACT_ENCODE, 1'b1, "?", 8'h00));
		dir_rows.push_back(plain_row(ACT_ENCODE, 1'b1, "z", 8'h00));
		// masked code 0, masked figures shift and character, start flag to letters
		dir_rows.push_back(plain_row(ACT_DECODE, 1'b0, 8'h00, 8'hE0));
		dir_rows.push_back(plain_row(ACT_DECODE, 1'b0, 8'h00, 8'h7B));
		dir_rows.push_back(plain_row(ACT_DECODE, 1'b0, 8'h00, 8'h9C));
		dir_rows.push_back(plain_row(ACT_DECODE, 1'b1, 8'h00, 8'h1C));

		foreach (dir_rows[i]) begin
			send_item(dir_rows[i].it, dir_rows[i].known, dir_rows[i].want);
		end
		drain_results();

		// random part: three idling profiles, drained between them
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 11;
					recv_stall_pct = 73;
				end
				1: begin
					send_idle_pct = 73;
					recv_stall_pct = 11;
				end
				default: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				it.char_in = 8'($urandom_range(0, 255));
				it.code_in = 8'($urandom_range(0, 255));
				it.start_of_message = ($urandom_range(0, 11) == 0);
				if (pick < 45) begin
					// printable text, mostly mapped
					it.action = ACT_ENCODE;
					it.char_in = 8'($urandom_range(32, 126));
				end else if (pick < 55) begin
					it.action = ACT_ENCODE;
				end else if (pick < 65) begin
					// shift codes with random upper bits
					it.action = ACT_DECODE;
					it.code_in[4:0] = $urandom_range(0, 1) ? CODE_LTRS : CODE_FIGS;
				end else begin
					it.action = ACT_DECODE;
				end
				send_item(it, 1'b0, '0);
			end
			drain_results();
		end

		// let anything stray arrive before the verdict
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
